/* rtl/mpqs_pkg.sv */
`default_nettype none
package mpqs_pkg;

  localparam int SLOTS_DEF         = 16;
  localparam int KEY_WIDTH_DEF     = 16;
  localparam int PAYLOAD_WIDTH_DEF = 16;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_POLL = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] priority_req;
    logic [15:0] payload;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_priority;
    logic [15:0] out_payload;
    logic [4:0]  count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREE_SCAN,
    ST_RESCAN,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

/* rtl/max_priority_queue_slots.sv */
`default_nettype none
// Latency: every accepted command gives its result (done high) in the cycle after the transfer.
// Add: busy afterwards for the forward search for the next free slot, one valid bit a cycle
//   (not busy at all when the add fills the queue or is refused).
// Poll: busy while the rescan reads every slot, one slot read a cycle, plus one compare drain,
//   so no new command is taken until the drain ends; a refused poll leaves the block ready at once.
// rst (synchronous) empties the queue; the receiver cannot stall results.
module max_priority_queue_slots #(
  parameter int SLOTS         = mpqs_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH     = mpqs_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = mpqs_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire mpqs_pkg::req_t req,
  output logic                done,
  output mpqs_pkg::rsp_t      result
);

  localparam int IDXW = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  mpqs_pkg::state_t state, state_next;

  // Occupancy lives in flops so reset empties the queue at once.
  logic [SLOTS-1:0]         slot_valid;
  // Key/payload storage: one write port (add), one registered read port (rescan).
  logic [KEY_WIDTH-1:0]     slot_priority [SLOTS];
  logic [PAYLOAD_WIDTH-1:0] slot_payload  [SLOTS];

  // Copy of the current maximum entry, so a poll answers without a memory read.
  logic                     max_known;
  logic [IDXW-1:0]          max_slot;
  logic [KEY_WIDTH-1:0]     max_pri;
  logic [PAYLOAD_WIDTH-1:0] max_pay;

  logic [CNTW-1:0]          item_count;
  // Lowest free slot whenever the block is idle and the queue is not full.
  logic [IDXW-1:0]          next_free;
  // Shared walk counter: free-slot search after an add, slot rescan after a poll.
  logic [IDXW-1:0]          scan_idx;

  // Rescan read stage: registered memory data plus the slot it came from.
  logic                     cmp_en;
  logic                     rd_vld;
  logic [IDXW-1:0]          rd_idx;
  logic [KEY_WIDTH-1:0]     rd_pri;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  logic                     accept;
  logic                     is_add;
  logic                     full;
  logic                     empty;
  logic                     add_ok;
  logic                     poll_ok;
  logic [KEY_WIDTH-1:0]     cmp_key;
  logic                     key_gt_max;
  logic                     add_takes_max;
  logic                     cmp_takes_max;
  logic [KEY_WIDTH-1:0]     key_in;
  logic [PAYLOAD_WIDTH-1:0] pay_in;
  logic [CNTW-1:0]          count_after;

  assign accept  = start && !busy;
  assign is_add  = (req.mode == mpqs_pkg::MODE_ADD);
  assign full    = (item_count == CNTW'(SLOTS));
  assign empty   = (item_count == '0) || !max_known;
  assign add_ok  = is_add && !full;
  assign poll_ok = !is_add && !empty;
  assign key_in  = KEY_WIDTH'(req.priority_req);
  assign pay_in  = PAYLOAD_WIDTH'(req.payload);

  // One comparator against the held maximum: the incoming key while idle,
  // the slot read back while rescanning.
  assign cmp_key    = cmp_en ? rd_pri : key_in;
  assign key_gt_max = (cmp_key > max_pri);

  // An add displaces the maximum only on a strictly greater key.
  assign add_takes_max = !max_known || key_gt_max;
  // Rescan: first valid slot wins, later ones only when strictly greater.
  assign cmp_takes_max = cmp_en && rd_vld && (!max_known || key_gt_max);

  always_comb begin
    if (add_ok) begin
      count_after = item_count + CNTW'(1);
    end else if (poll_ok) begin
      count_after = item_count - CNTW'(1);
    end else begin
      count_after = item_count;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpqs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    busy       = (state != mpqs_pkg::ST_IDLE);
    unique case (state)
      mpqs_pkg::ST_IDLE: begin
        if (accept) begin
          if (add_ok && (count_after != CNTW'(SLOTS))) begin
            state_next = mpqs_pkg::ST_FREE_SCAN;
          end else if (poll_ok) begin
            state_next = mpqs_pkg::ST_RESCAN;
          end
        end
      end
      mpqs_pkg::ST_FREE_SCAN: begin
        if (!slot_valid[scan_idx]) begin
          state_next = mpqs_pkg::ST_IDLE;
        end
      end
      mpqs_pkg::ST_RESCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = mpqs_pkg::ST_DRAIN;
        end
      end
      mpqs_pkg::ST_DRAIN: begin
        state_next = mpqs_pkg::ST_IDLE;
      end
      default: begin
        state_next = mpqs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      max_known  <= 1'b0;
      max_slot   <= '0;
      item_count <= '0;
      next_free  <= '0;
      scan_idx   <= '0;
      cmp_en     <= 1'b0;
      done       <= 1'b0;
    end else begin
      done   <= accept;
      cmp_en <= (state == mpqs_pkg::ST_RESCAN);
      case (state)
        mpqs_pkg::ST_IDLE: begin
          if (accept) begin
            item_count <= count_after;
            if (add_ok) begin
              slot_valid[next_free] <= 1'b1;
              scan_idx              <= next_free + IDXW'(1);
              if (add_takes_max) begin
                max_known <= 1'b1;
                max_slot  <= next_free;
              end
            end else if (poll_ok) begin
              slot_valid[max_slot] <= 1'b0;
              // Coming from full, next_free is stale: the freed slot is the only free one.
              if (full || (max_slot < next_free)) begin
                next_free <= max_slot;
              end
              max_known <= 1'b0;
              max_slot  <= '0;
              scan_idx  <= '0;
            end
          end
        end
        mpqs_pkg::ST_FREE_SCAN: begin
          if (!slot_valid[scan_idx]) begin
            next_free <= scan_idx;
          end else begin
            scan_idx <= scan_idx + IDXW'(1);
          end
        end
        mpqs_pkg::ST_RESCAN: begin
          scan_idx <= scan_idx + IDXW'(1);
        end
        default: begin
        end
      endcase
      if (cmp_takes_max) begin
        max_known <= 1'b1;
        max_slot  <= rd_idx;
      end
    end
  end

  // Storage and payload registers (no reset needed)
  always_ff @(posedge clk) begin
    if ((state == mpqs_pkg::ST_IDLE) && accept && add_ok) begin
      slot_priority[next_free] <= key_in;
      slot_payload[next_free]  <= pay_in;
      if (add_takes_max) begin
        max_pri <= key_in;
        max_pay <= pay_in;
      end
    end
    if (cmp_takes_max) begin
      max_pri <= rd_pri;
      max_pay <= rd_pay;
    end
    rd_pri <= slot_priority[scan_idx];
    rd_pay <= slot_payload[scan_idx];
    rd_vld <= slot_valid[scan_idx];
    rd_idx <= scan_idx;
    if (accept) begin
      result.count <= 5'(count_after);
      if (poll_ok) begin
        result.status       <= mpqs_pkg::STATUS_OK;
        result.out_priority <= 16'(max_pri);
        result.out_payload  <= 16'(max_pay);
      end else begin
        result.out_priority <= '0;
        result.out_payload  <= '0;
        if (add_ok) begin
          result.status <= mpqs_pkg::STATUS_OK;
        end else if (is_add) begin
          result.status <= mpqs_pkg::STATUS_FULL;
        end else begin
          result.status <= mpqs_pkg::STATUS_EMPTY;
        end
      end
    end
  end

  // Every transfer yields exactly one result, in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("transfer without result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result without transfer");

  // While idle, stored elements always have a known maximum.
  a_max_known: assert property (@(posedge clk) disable iff (rst)
    (state == mpqs_pkg::ST_IDLE) && (item_count != '0) |-> max_known)
    else $error("elements stored but no maximum tracked");

  // Free slot index names a free slot whenever an add could use it.
  a_next_free: assert property (@(posedge clk) disable iff (rst)
    (state == mpqs_pkg::ST_IDLE) && !full |-> !slot_valid[next_free])
    else $error("free slot index names an occupied slot");

endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS  = mpqs_pkg::SLOTS_DEF;
  localparam int N_RANDOM   = 1200;
  localparam int PHASE_LEN  = 40;
  // longest busy stretch after a transfer is a poll: the rescan and the drain, plus the strobe
  localparam int DRAIN_CYC  = NUM_SLOTS + 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  mpqs_pkg::req_t req = '0;
  logic busy;
  logic done;
  mpqs_pkg::rsp_t result;

  max_priority_queue_slots u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Queue model: valid bit, key and payload per slot, plus the tracked maximum.
  // ---------------------------------------------------------------------------
  logic        slot_used [NUM_SLOTS];
  logic [15:0] slot_key  [NUM_SLOTS];
  logic [15:0] slot_data [NUM_SLOTS];
  int          top_slot  = 0;
  logic        top_known = 1'b0;
  int          n_stored  = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_data[i] = '0;
    end
  end

  // Applies one command to the model and returns the result it should give.
  task automatic queue_op(input mpqs_pkg::req_t cmd, output mpqs_pkg::rsp_t want);
    logic placed;
    want = '0;
    want.status = mpqs_pkg::STATUS_OK;
    if (cmd.mode == mpqs_pkg::MODE_ADD) begin
      if (n_stored >= NUM_SLOTS) begin
        want.status = mpqs_pkg::STATUS_FULL;
      end else begin
        placed = 1'b0;
        // lowest free slot takes it; a tie with the max never displaces it
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !slot_used[i]) begin
            placed       = 1'b1;
            slot_used[i] = 1'b1;
            slot_key[i]  = cmd.priority_req;
            slot_data[i] = cmd.payload;
            if (!top_known || cmd.priority_req > slot_key[top_slot]) begin
              top_slot  = i;
              top_known = 1'b1;
            end
            n_stored++;
          end
        end
      end
    end else if (n_stored == 0 || !top_known) begin
      want.status = mpqs_pkg::STATUS_EMPTY;
    end else begin
      want.out_priority   = slot_key[top_slot];
      want.out_payload    = slot_data[top_slot];
      slot_used[top_slot] = 1'b0;
      n_stored--;
      // rescan in index order, strictly greater wins: lowest index among equals
      top_known = 1'b0;
      top_slot  = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_used[i] && (!top_known || slot_key[i] > slot_key[top_slot])) begin
          top_slot  = i;
          top_known = 1'b1;
        end
      end
    end
    want.count = n_stored[4:0];
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus backlog and driver
  // ---------------------------------------------------------------------------
  mpqs_pkg::req_t cmd_backlog [$];
  mpqs_pkg::rsp_t rsp_due [$];
  logic failed = 1'b0;
  logic took = 1'b0;     // a transfer happened at the last rising edge
  int   hold = 0;        // idle cycles left before the next command is offered
  int   stretch_left = 0;
  logic stretch_calm = 1'b0;

  // Gap before the next command: alternates stretches of back-to-back
  // commands with stretches of random gaps so idle time lands everywhere.
  function automatic int next_gap();
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(10, 40);
      stretch_calm = ($urandom_range(0, 2) == 0);
    end
    stretch_left--;
    return stretch_calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Driver: all input changes on the falling edge. start stays high across
  // back-to-back transfers; only req moves then.
  always @(negedge clk) begin
    int gap;
    if (!rst) begin
      if (start && took) begin
        gap = next_gap();
        if (gap == 0 && cmd_backlog.size() > 0) begin
          req <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
          hold = gap;
        end
      end else if (!start) begin
        if (hold > 0) begin
          hold--;
        end else if (cmd_backlog.size() > 0) begin
          req   <= cmd_backlog.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks the strobed result first (it belongs to an earlier
  // transfer), then books the prediction for a transfer at this edge.
  always @(posedge clk) begin
    mpqs_pkg::rsp_t want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      if (done) begin
        if (rsp_due.size() == 0) begin
          $error("result with no command outstanding: %p", result);
          failed = 1'b1;
        end else begin
          want = rsp_due.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            failed = 1'b1;
          end
          if (result.out_priority !== want.out_priority) begin
            $error("out_priority: expected %h, got %h", want.out_priority,
                   result.out_priority);
            failed = 1'b1;
          end
          if (result.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, got %h", want.out_payload,
                   result.out_payload);
            failed = 1'b1;
          end
          if (result.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, result.count);
            failed = 1'b1;
          end
        end
      end
      took <= start && !busy;
      if (start && !busy) begin
        queue_op(req, want);
        rsp_due.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command builders
  // ---------------------------------------------------------------------------
  function automatic mpqs_pkg::req_t add_cmd(logic [15:0] key, logic [15:0] data);
    mpqs_pkg::req_t c;
    c.mode         = mpqs_pkg::MODE_ADD;
    c.priority_req = key;
    c.payload      = data;
    return c;
  endfunction

  // Poll fields are don't-care; random bits there exercise that.
  function automatic mpqs_pkg::req_t poll_cmd();
    mpqs_pkg::req_t c;
    c.mode         = mpqs_pkg::MODE_POLL;
    c.priority_req = 16'($urandom_range(0, 16'hFFFF));
    c.payload      = 16'($urandom_range(0, 16'hFFFF));
    return c;
  endfunction

  // Keys: many from a narrow band so ties are common, some at the extremes.
  function automatic logic [15:0] rand_key();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int add_pct;

    // directed: empty poll, zero key/payload, ties on add and on rescan
    cmd_backlog.push_back(poll_cmd());
    cmd_backlog.push_back(add_cmd(16'h0000, 16'h0000));
    cmd_backlog.push_back(add_cmd(16'h0000, 16'hFFFF));
    cmd_backlog.push_back(add_cmd(16'hFFFF, 16'hAAAA));
    cmd_backlog.push_back(add_cmd(16'hFFFF, 16'h5555));
    cmd_backlog.push_back(poll_cmd());
    cmd_backlog.push_back(poll_cmd());
    // fill up to full, then one refused add
    for (int i = 0; i < NUM_SLOTS - 2; i++)
      cmd_backlog.push_back(add_cmd(16'(i * 16'h1249), ~16'(i * 16'h0421)));
    cmd_backlog.push_back(add_cmd(16'hFFFF, 16'hFFFF));
    cmd_backlog.push_back(poll_cmd());

    // random: phases lean toward adds (runs into full), toward polls (drains empty) or are balanced
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       add_pct = 15;
          1:       add_pct = 50;
          default: add_pct = 85;
        endcase
      end
      if ($urandom_range(0, 99) < add_pct)
        cmd_backlog.push_back(add_cmd(rand_key(), 16'($urandom_range(0, 16'hFFFF))));
      else
        cmd_backlog.push_back(poll_cmd());
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || start || rsp_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (rsp_due.size() != 0) begin
      $error("%0d results never arrived", rsp_due.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: worst case is about 1250 commands, each with the longest gap, a poll's busy stretch
  // and the strobe, roughly 0.5 ms; allow ten times that.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
